>>> rtl/core/kpsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types, register indexes and the key map of the keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

  // Widths of the item fields
  localparam int unsigned LEVELS_W = 3;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned NUM_COLS = 3;
  localparam int unsigned NUM_ROWS = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT         = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] DEBOUNCE_THRESHOLD_RST = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] IDLE_LIMIT_RST         = COUNT_W'(40);

  // Release code reported when the idle count runs out
  localparam logic [CHAR_W-1:0] CHAR_RELEASE = '0;

  // Live configuration, handed to the step logic
  typedef struct packed {
    logic [COUNT_W-1:0] debounce_threshold;
    logic [COUNT_W-1:0] idle_limit;
  } kpsd_cfg_t;

  // ASCII key map: rows 1-2-3, 4-5-6, 7-8-9, *-0-#
  localparam logic [CHAR_W-1:0] KEY_MAP [NUM_ROWS][NUM_COLS] = '{
    '{7'h31, 7'h32, 7'h33},
    '{7'h34, 7'h35, 7'h36},
    '{7'h37, 7'h38, 7'h39},
    '{7'h2A, 7'h30, 7'h23}
  };

  // Look up the key at a row and a column
  function automatic logic [CHAR_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
                                                   input logic [1:0] col);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_RELEASE;
    case (col)
      2'd0:    ch = KEY_MAP[row][0];
      2'd1:    ch = KEY_MAP[row][1];
      2'd2:    ch = KEY_MAP[row][2];
      default: ch = CHAR_RELEASE;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kpsd_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_in_reg
// Input register: holds one scan step until the step logic takes it.
// ----------------------------------------------------------------------------
module kpsd_in_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [kpsd_pkg::LEVELS_W-1:0]  in_levels,
  input  wire logic                           in_tick,
  input  wire logic                           take,
  output logic                                step_valid,
  output logic [kpsd_pkg::LEVELS_W-1:0]       step_levels,
  output logic                                step_tick
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [kpsd_pkg::LEVELS_W-1:0] levels_r;
  logic                          tick_r;

  // Accept while empty or while the held item leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  // Control flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      levels_r <= in_levels;
      tick_r   <= in_tick;
    end
  end

  assign step_valid  = valid_r;
  assign step_levels = levels_r;
  assign step_tick   = tick_r;

endmodule
`default_nettype wire

>>> rtl/core/kpsd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_step
// Scan state, debounce counters and the result register.
// ----------------------------------------------------------------------------
module kpsd_step (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire kpsd_pkg::kpsd_cfg_t               cfg,
  input  wire logic                              step_valid,
  input  wire logic [kpsd_pkg::LEVELS_W-1:0]     step_levels,
  input  wire logic                              step_tick,
  output logic                                   take,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [kpsd_pkg::ROW_W-1:0]             out_next_row,
  output logic                                   out_key_event,
  output logic [kpsd_pkg::CHAR_W-1:0]            out_key_char
);

  localparam int unsigned CW = kpsd_pkg::COUNT_W;

  logic [kpsd_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [CW-1:0]               cnt_r   [kpsd_pkg::NUM_COLS];
  logic [CW-1:0]               cnt_nxt [kpsd_pkg::NUM_COLS];
  logic [CW-1:0]               cnt_inc [kpsd_pkg::NUM_COLS];
  logic [CW-1:0]               idle_r, idle_nxt, idle_inc;
  logic [kpsd_pkg::NUM_COLS-1:0] over;
  logic                        hit;
  logic [1:0]                  hit_col;
  logic                        event_nxt;
  logic [kpsd_pkg::CHAR_W-1:0] char_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [kpsd_pkg::ROW_W-1:0]  out_row_r;
  logic                        out_event_r;
  logic [kpsd_pkg::CHAR_W-1:0] out_char_r;

  // Move the held item on when the result register is free
  assign take = step_valid && (!out_valid_r || out_ready);

  // Count a tick on the first high column
  always_comb begin
    cnt_inc[0] = cnt_r[0];
    cnt_inc[1] = cnt_r[1];
    cnt_inc[2] = cnt_r[2];
    idle_inc   = idle_r;
    if (step_tick) begin
      idle_inc = idle_r + CW'(1);
      if (step_levels[0]) begin
        cnt_inc[0] = cnt_r[0] + CW'(1);
      end else if (step_levels[1]) begin
        cnt_inc[1] = cnt_r[1] + CW'(1);
      end else if (step_levels[2]) begin
        cnt_inc[2] = cnt_r[2] + CW'(1);
      end
    end
  end

  // Find the lowest column over threshold
  always_comb begin
    for (int c = 0; c < kpsd_pkg::NUM_COLS; c++) begin
      over[c] = cnt_inc[c] > cfg.debounce_threshold;
    end
    hit     = step_tick && (over != '0);
    hit_col = 2'd0;
    if (over[0]) begin
      hit_col = 2'd0;
    end else if (over[1]) begin
      hit_col = 2'd1;
    end else begin
      hit_col = 2'd2;
    end
  end

  // Report a key, a release, or nothing
  always_comb begin
    cnt_nxt   = cnt_inc;
    idle_nxt  = idle_inc;
    event_nxt = 1'b0;
    char_nxt  = kpsd_pkg::CHAR_RELEASE;
    if (hit) begin
      cnt_nxt   = '{default: '0};
      idle_nxt  = '0;
      event_nxt = 1'b1;
      char_nxt  = kpsd_pkg::key_lookup(row_r, hit_col);
    end else if (step_tick && (idle_inc > cfg.idle_limit)) begin
      idle_nxt  = '0;
      event_nxt = 1'b1;
    end
    row_nxt = row_r + kpsd_pkg::ROW_W'(1);
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Scan state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      cnt_r       <= '{default: '0};
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        row_r  <= row_nxt;
        cnt_r  <= cnt_nxt;
        idle_r <= idle_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_row_r   <= row_nxt;
      out_event_r <= event_nxt;
      out_char_r  <= char_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_row  = out_row_r;
  assign out_key_event = out_event_r;
  assign out_key_char  = out_char_r;

endmodule
`default_nettype wire

>>> rtl/core/keypad_scan_debounce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// Scanner and debouncer for a 4-row by 3-column matrix keypad.
// ----------------------------------------------------------------------------
// Each input item is one scan step: the three column levels sampled while the
// current row is driven, plus a debounce tick flag. Every item gives exactly
// one result item with the row to drive next and, when a key is accepted or
// the idle count runs out, a key event with its ASCII code (0 for release).
// The block takes one item per clock while the result output is not stalled.
// An accepted item is held in the input register and moves into the result
// register when that register is free or its item is being taken. The
// counter update is combinational between the two registers; a stalled
// result holds the input side.
// Write the thresholds only while no item is in flight.
// ----------------------------------------------------------------------------
module keypad_scan_debounce (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Scan step input
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [2:0] column_levels
  input  wire logic                               in_tuser,   // [0] tick
  // Result output
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [15:0]                             out_tdata,  // [1:0] next_row,
                                                              // [8:2] key_char
  output logic                                    out_tuser,  // [0] key_event
  // Configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [kpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kpsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  kpsd_pkg::kpsd_cfg_t                 cfg_r;
  logic                                take;
  logic                                step_valid;
  logic [kpsd_pkg::LEVELS_W-1:0]       step_levels;
  logic                                step_tick;
  logic [kpsd_pkg::ROW_W-1:0]          next_row;
  logic                                key_event;
  logic [kpsd_pkg::CHAR_W-1:0]         key_char;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_threshold <= kpsd_pkg::DEBOUNCE_THRESHOLD_RST;
      cfg_r.idle_limit         <= kpsd_pkg::IDLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kpsd_pkg::REG_DEBOUNCE_THRESHOLD: cfg_r.debounce_threshold <= cfg_data;
        kpsd_pkg::REG_IDLE_LIMIT:         cfg_r.idle_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

  kpsd_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_levels   (in_tdata[kpsd_pkg::LEVELS_W-1:0]),
    .in_tick     (in_tuser),
    .take        (take),
    .step_valid  (step_valid),
    .step_levels (step_levels),
    .step_tick   (step_tick)
  );

  kpsd_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .step_valid    (step_valid),
    .step_levels   (step_levels),
    .step_tick     (step_tick),
    .take          (take),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_next_row  (next_row),
    .out_key_event (key_event),
    .out_key_char  (key_char)
  );

  // Pack the result item
  assign out_tdata = {7'd0, key_char, next_row};
  assign out_tuser = key_event;

endmodule
`default_nettype wire
